[rtl/core/dtk_pkg.sv]
// Shared types, constants and codes for the dual top-k ranker.
`timescale 1ns / 1ps
`default_nettype none

package dtk_pkg;

    localparam int DEPTH       = 32;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W       = $clog2(DEPTH + 1);
    localparam int CFG_W       = 6;
    localparam int RANK_W      = 5;
    localparam int USER_W      = 20;
    localparam int VAL_W       = 32;
    localparam int DEFAULT_LEN = 30;

    localparam int S_TDATA_W   = 96;
    localparam int M_TDATA_W   = 88;

    localparam logic signed [VAL_W-1:0] M_LIMIT = 32'sd1000000000;
    localparam logic signed [VAL_W-1:0] K_LIMIT = 32'sd1000000;

    // reciprocals: q = (x * RECIP) >> SHIFT, exact for 0 <= x < 2^31
    localparam logic [31:0] RECIP_K = 32'd2199023256;
    localparam int          SHIFT_K = 41;
    localparam logic [31:0] RECIP_M = 32'd2251799814;
    localparam int          SHIFT_M = 51;

    typedef enum logic [0:0] {
        CMD_OFFER = 1'b0,
        CMD_READ  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        SFX_NONE = 2'd0,
        SFX_K    = 2'd1,
        SFX_M    = 2'd2
    } sfx_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_WRITE
    } bk_state_t;

    typedef struct packed {
        cmd_t                    command;
        logic [USER_W-1:0]       user_index;
        logic signed [VAL_W-1:0] post_count;
        logic signed [VAL_W-1:0] money;
        logic                    eligible;
        logic                    read_list;
        logic [RANK_W-1:0]       read_rank;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic [USER_W-1:0]       rank_user;
        logic signed [VAL_W-1:0] rank_value;
        logic signed [VAL_W-1:0] display_value;
        sfx_t                    display_suffix;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/dtk_front.sv]
// Front end: accepts requests, unpacks the fields and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module dtk_front (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire [dtk_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire                         s_tuser,
    output dtk_pkg::queue_head_t        head,
    input  wire                         pop
);

    dtk_pkg::item_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    dtk_pkg::item_t decoded;
    logic           push;
    logic           do_pop;

    always_comb
    begin
        decoded.command    = dtk_pkg::cmd_t'(s_tuser);
        decoded.user_index = s_tdata[19:0];
        decoded.post_count = s_tdata[51:20];
        decoded.money      = s_tdata[83:52];
        decoded.eligible   = s_tdata[84];
        decoded.read_list  = s_tdata[85];
        decoded.read_rank  = s_tdata[90:86];
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign do_pop   = pop && (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = push   ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= decoded;
        end
    end

    always_comb
    begin
        head.valid = (count_reg != 2'd0);
        head.item  = mem_reg[rd_ptr_reg];
    end

endmodule

`default_nettype wire

[rtl/core/dtk_list.sv]
// One ranked list: a row of compare-and-shift cells with a rank read mux.
`timescale 1ns / 1ps
`default_nettype none

module dtk_list (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                ins_en,
    input  wire [dtk_pkg::USER_W-1:0]          ins_user,
    input  wire signed [dtk_pkg::VAL_W-1:0]    ins_value,
    input  wire [dtk_pkg::LEN_W-1:0]           eff_len,
    input  wire [dtk_pkg::IDX_W-1:0]           rd_idx,
    output logic [dtk_pkg::USER_W-1:0]         rd_user,
    output logic signed [dtk_pkg::VAL_W-1:0]   rd_value
);

    logic [dtk_pkg::USER_W-1:0]       users_reg  [dtk_pkg::DEPTH];
    logic signed [dtk_pkg::VAL_W-1:0] values_reg [dtk_pkg::DEPTH];
    logic [dtk_pkg::DEPTH-1:0]        ge;

    // list stays sorted, so ge is a run of ones followed by zeros
    always_comb
    begin
        for (int i = 0; i < dtk_pkg::DEPTH; i++)
        begin
            ge[i] = (values_reg[i] >= ins_value);
        end
    end

    for (genvar g = 0; g < dtk_pkg::DEPTH; g++)
    begin : g_cell
        logic in_len;
        logic prev_ge;

        assign in_len = (32'(g) < 32'(eff_len));

        if (g == 0)
        begin : g_first
            assign prev_ge = 1'b1;
        end
        else
        begin : g_rest
            assign prev_ge = ge[g-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                users_reg[g]  <= '0;
                values_reg[g] <= '0;
            end
            else if (ins_en && in_len && !ge[g])
            begin
                if (prev_ge)
                begin
                    users_reg[g]  <= ins_user;
                    values_reg[g] <= ins_value;
                end
                else
                begin
                    users_reg[g]  <= users_reg[(g > 0) ? g - 1 : 0];
                    values_reg[g] <= values_reg[(g > 0) ? g - 1 : 0];
                end
            end
        end
    end

    assign rd_user  = users_reg[rd_idx];
    assign rd_value = values_reg[rd_idx];

endmodule

`default_nettype wire

[rtl/core/dtk_back.sv]
// Back end: applies offers to both lists and serves reads with display scaling.
`timescale 1ns / 1ps
`default_nettype none

module dtk_back (
    input  wire                         clk,
    input  wire                         rst_n,
    input  dtk_pkg::queue_head_t        head,
    output logic                        pop,
    input  wire [dtk_pkg::CFG_W-1:0]    list_length,
    output logic                        res_valid,
    input  wire                         res_ready,
    output dtk_pkg::result_t            res
);

    dtk_pkg::bk_state_t state_reg, state_next;

    logic [dtk_pkg::USER_W-1:0]       pick_user_reg;
    logic signed [dtk_pkg::VAL_W-1:0] pick_val_reg;
    dtk_pkg::sfx_t                    pick_sfx_reg;
    logic [62:0]                      prod_reg;
    logic                             out_valid_reg;
    dtk_pkg::result_t                 out_reg;

    logic                             ins_en;
    logic                             load_pick;
    logic                             load_out;
    logic [dtk_pkg::LEN_W-1:0]        eff_len;
    logic [dtk_pkg::IDX_W-1:0]        rd_idx;
    logic [dtk_pkg::USER_W-1:0]       post_user, money_user, sel_user, pick_user;
    logic signed [dtk_pkg::VAL_W-1:0] post_val, money_val, sel_val, pick_val;
    dtk_pkg::sfx_t                    pick_sfx;
    logic                             in_range;
    logic [31:0]                      recip;
    logic signed [dtk_pkg::VAL_W-1:0] disp;

    // zero selects the default length; anything beyond the cells saturates
    always_comb
    begin
        int n;
        n = (list_length == '0) ? dtk_pkg::DEFAULT_LEN : 32'(list_length);
        if (n > dtk_pkg::DEPTH)
        begin
            n = dtk_pkg::DEPTH;
        end
        eff_len = dtk_pkg::LEN_W'(n);
    end

    assign rd_idx = dtk_pkg::IDX_W'(head.item.read_rank);

    dtk_list u_post_list (
        .clk      (clk),
        .rst_n    (rst_n),
        .ins_en   (ins_en),
        .ins_user (head.item.user_index),
        .ins_value(head.item.post_count),
        .eff_len  (eff_len),
        .rd_idx   (rd_idx),
        .rd_user  (post_user),
        .rd_value (post_val)
    );

    dtk_list u_money_list (
        .clk      (clk),
        .rst_n    (rst_n),
        .ins_en   (ins_en),
        .ins_user (head.item.user_index),
        .ins_value(head.item.money),
        .eff_len  (eff_len),
        .rd_idx   (rd_idx),
        .rd_user  (money_user),
        .rd_value (money_val)
    );

    always_comb
    begin
        in_range  = (32'(head.item.read_rank) < 32'(eff_len));
        sel_user  = head.item.read_list ? money_user : post_user;
        sel_val   = head.item.read_list ? money_val  : post_val;
        pick_user = in_range ? sel_user : '0;
        pick_val  = in_range ? sel_val  : '0;
        if (pick_val > dtk_pkg::M_LIMIT)
        begin
            pick_sfx = dtk_pkg::SFX_M;
        end
        else if (pick_val > dtk_pkg::K_LIMIT)
        begin
            pick_sfx = dtk_pkg::SFX_K;
        end
        else
        begin
            pick_sfx = dtk_pkg::SFX_NONE;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        ins_en     = 1'b0;
        load_pick  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            dtk_pkg::BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.item.command == dtk_pkg::CMD_READ)
                    begin
                        load_pick  = 1'b1;
                        state_next = dtk_pkg::BK_MUL;
                    end
                    else
                    begin
                        ins_en = head.item.eligible;
                    end
                end
            end
            dtk_pkg::BK_MUL:
            begin
                state_next = dtk_pkg::BK_WRITE;
            end
            dtk_pkg::BK_WRITE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    load_out   = 1'b1;
                    state_next = dtk_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = dtk_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtk_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign recip = (pick_sfx_reg == dtk_pkg::SFX_M) ? dtk_pkg::RECIP_M : dtk_pkg::RECIP_K;

    always_comb
    begin
        case (pick_sfx_reg)
            dtk_pkg::SFX_M:    disp = dtk_pkg::VAL_W'(prod_reg >> dtk_pkg::SHIFT_M);
            dtk_pkg::SFX_K:    disp = dtk_pkg::VAL_W'(prod_reg >> dtk_pkg::SHIFT_K);
            default:           disp = pick_val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_pick)
        begin
            pick_user_reg <= pick_user;
            pick_val_reg  <= pick_val;
            pick_sfx_reg  <= pick_sfx;
        end
        if (state_reg == dtk_pkg::BK_MUL)
        begin
            // scaled values are always positive, so the sign bit is dropped
            prod_reg <= 63'(pick_val_reg[30:0]) * 63'(recip);
        end
        if (load_out)
        begin
            out_reg.rank_user      <= pick_user_reg;
            out_reg.rank_value     <= pick_val_reg;
            out_reg.display_value  <= disp;
            out_reg.display_suffix <= pick_sfx_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

[rtl/core/dual_top_k_ranker_unit.sv]
// Top level of the dual top-k ranker: stream ports, length register, front and back ends.
`timescale 1ns / 1ps
`default_nettype none

// Keeps two descending top-k lists (by post count and by money) of up to 32
// ranks each, cleared to zero at reset. A request with tuser 0 offers a
// record and gives no response; an eligible offer goes below every entry of
// equal or greater value in each list. A request with tuser 1 reads one rank
// of one list and gives one response with the raw value and a display value
// scaled to K or M above the K limit. A two-entry queue sits between the
// input port and the engine. An offer is applied in the idle state; a read
// steps through list select, reciprocal multiply and output load, stalling
// there while the output register waits on m_tready. list_length applies to
// requests that reach the engine after the write; cfg_ready is always high.
module dual_top_k_ranker_unit (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // [19:0] user_index, [51:20] post_count, [83:52] money, [84] eligible,
    // [85] read_list, [90:86] read_rank, [95:91] zero
    input  wire [dtk_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] command
    input  wire                          s_tuser,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // [19:0] rank_user, [51:20] rank_value, [83:52] display_value,
    // [85:84] display_suffix, [87:86] zero
    output logic [dtk_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [dtk_pkg::CFG_W-1:0]     cfg_data
);

    logic [dtk_pkg::CFG_W-1:0] list_length_reg, list_length_next;
    dtk_pkg::queue_head_t      head;
    logic                      pop;
    dtk_pkg::result_t          res;

    assign cfg_ready        = 1'b1;
    assign list_length_next = (cfg_valid && cfg_ready) ? cfg_data : list_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_length_reg <= dtk_pkg::CFG_W'(dtk_pkg::DEFAULT_LEN);
        end
        else
        begin
            list_length_reg <= list_length_next;
        end
    end

    dtk_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .head    (head),
        .pop     (pop)
    );

    dtk_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .list_length(list_length_reg),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {2'b00, res.display_suffix, res.display_value,
                      res.rank_value, res.rank_user};

endmodule

`default_nettype wire

[rtl/core/dtk_checker.sv]
// Port-level checks for the dual top-k ranker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dtk_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [dtk_pkg::M_TDATA_W-1:0] m_tdata
);

    logic signed [dtk_pkg::VAL_W-1:0] rank_value;
    logic signed [dtk_pkg::VAL_W-1:0] display_value;
    logic [1:0]                       sfx;

    assign rank_value    = m_tdata[51:20];
    assign display_value = m_tdata[83:52];
    assign sfx           = m_tdata[85:84];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("response dropped while stalled");

    a_plain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && sfx == dtk_pkg::SFX_NONE |->
            display_value == rank_value && rank_value <= dtk_pkg::K_LIMIT)
        else $error("unscaled display value mismatch");

    // just above the K threshold the scaled value is exactly 1000
    a_kilo: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && sfx == dtk_pkg::SFX_K |->
            rank_value > dtk_pkg::K_LIMIT && rank_value <= dtk_pkg::M_LIMIT
            && display_value >= 32'sd1000 && display_value <= 32'sd1000000)
        else $error("K suffix on wrong range");

    a_mega: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && sfx == dtk_pkg::SFX_M |->
            rank_value > dtk_pkg::M_LIMIT && display_value >= 32'sd1000
            && display_value <= 32'sd2147)
        else $error("M suffix on wrong range");

endmodule

bind dual_top_k_ranker_unit dtk_checker u_dtk_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire

[dv/dual_top_k_ranker_unit_tb.sv]
// Self-checking testbench for the dual top-k ranker: random stream traffic against a ranking predictor.
`timescale 1ns / 1ps

module dual_top_k_ranker_unit_tb;

    import dtk_pkg::*;

    localparam int PHASE_ITEMS = 145;
    localparam int SETTLE      = 16;
    localparam logic signed [VAL_W-1:0] DIV_M = 32'sd1000000;
    localparam logic signed [VAL_W-1:0] DIV_K = 32'sd1000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;

    // predictor state: index 0 ranks by posts, 1 by money
    logic [USER_W-1:0]       rank_user_tab [2][DEPTH];
    logic signed [VAL_W-1:0] rank_val_tab  [2][DEPTH];
    logic [CFG_W-1:0]        list_len;

    item_t   pending_reqs [$];
    result_t due_results  [$];

    bit in_taken   = 1'b0;
    bit calm       = 1'b0;
    bit hold_off   = 1'b0;
    int send_gap   = 0;
    int recv_gap   = 0;
    int accepted_offers = 0;
    int accepted_reads  = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int lengths_used    = 1;

    dual_top_k_ranker_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int active_len();
        int n;
        n = int'(list_len);
        if (n == 0)
            n = DEFAULT_LEN;
        if (n > DEPTH)
            n = DEPTH;
        return n;
    endfunction

    // new entry goes below every entry of equal or greater value
    function automatic void rank_insert(input int lst, input logic [USER_W-1:0] user,
                                        input logic signed [VAL_W-1:0] value);
        int len;
        int k;
        len = active_len();
        k = len - 1;
        while (k >= 0 && rank_val_tab[lst][k] < value)
            k--;
        k++;
        if (k < len)
        begin
            for (int l = len - 1; l > k; l--)
            begin
                rank_user_tab[lst][l] = rank_user_tab[lst][l-1];
                rank_val_tab[lst][l]  = rank_val_tab[lst][l-1];
            end
            rank_user_tab[lst][k] = user;
            rank_val_tab[lst][k]  = value;
        end
    endfunction

    function automatic result_t rank_lookup(input logic lst, input logic [RANK_W-1:0] rank);
        result_t r;
        logic signed [VAL_W-1:0] v;
        r = '0;
        if (int'(rank) < active_len())
        begin
            v = rank_val_tab[lst][rank];
            r.rank_user  = rank_user_tab[lst][rank];
            r.rank_value = v;
            if (v > M_LIMIT)
            begin
                r.display_value  = v / DIV_M;
                r.display_suffix = SFX_M;
            end
            else if (v > K_LIMIT)
            begin
                r.display_value  = v / DIV_K;
                r.display_suffix = SFX_K;
            end
            else
            begin
                r.display_value  = v;
                r.display_suffix = SFX_NONE;
            end
        end
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            1:       v = M_LIMIT - 1 + $urandom_range(0, 2);
            2:       v = K_LIMIT - 1 + $urandom_range(0, 2);
            3:       v = $urandom_range(1000001, 1000000000);
            4:       v = $urandom_range(0, 1000000);
            5:       v = 32'd250000000 * $urandom_range(1, 4);  // tie pool
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic item_t random_request();
        item_t it;
        it.command    = ($urandom_range(0, 9) < 6) ? CMD_OFFER : CMD_READ;
        it.user_index = USER_W'($urandom_range(0, 20'hF_FFFF));
        it.post_count = pick_value();
        it.money      = pick_value();
        it.eligible   = ($urandom_range(0, 6) != 0);
        it.read_list  = 1'($urandom_range(0, 1));
        it.read_rank  = RANK_W'($urandom_range(0, 31));
        return it;
    endfunction

    function automatic item_t make_offer(input logic [USER_W-1:0] user,
                                         input logic [VAL_W-1:0] posts,
                                         input logic [VAL_W-1:0] money, input logic elig);
        item_t it;
        it = random_request();
        it.command    = CMD_OFFER;
        it.user_index = user;
        it.post_count = posts;
        it.money      = money;
        it.eligible   = elig;
        return it;
    endfunction

    function automatic item_t make_read(input logic lst, input logic [RANK_W-1:0] rank);
        item_t it;
        it = random_request();
        it.command   = CMD_READ;
        it.read_list = lst;
        it.read_rank = rank;
        return it;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // request driver
    always @(negedge clk)
    begin : drive_req
        item_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tuser  <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || in_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                send_gap <= $urandom_range(0, 17);
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                nxt = pending_reqs.pop_front();
                s_tuser  <= nxt.command;
                s_tdata  <= {5'b0, nxt.read_rank, nxt.read_list, nxt.eligible,
                             nxt.money, nxt.post_count, nxt.user_index};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // response sink
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            m_tready <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            recv_gap <= $urandom_range(0, 17);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: predict on accepted requests, check accepted responses
    always @(posedge clk)
    begin : watch
        item_t   req;
        result_t want;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
            list_len = CFG_W'(DEFAULT_LEN);
            for (int i = 0; i < DEPTH; i++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    rank_user_tab[j][i] = '0;
                    rank_val_tab[j][i]  = '0;
                end
            end
        end
        else
        begin
            in_taken <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready)
                list_len = cfg_data;
            if (s_tvalid && s_tready)
            begin
                req.command    = s_tuser ? CMD_READ : CMD_OFFER;
                req.user_index = s_tdata[19:0];
                req.post_count = s_tdata[51:20];
                req.money      = s_tdata[83:52];
                req.eligible   = s_tdata[84];
                req.read_list  = s_tdata[85];
                req.read_rank  = s_tdata[90:86];
                if (req.command == CMD_READ)
                begin
                    due_results.push_back(rank_lookup(req.read_list, req.read_rank));
                    accepted_reads++;
                end
                else
                begin
                    accepted_offers++;
                    if (req.eligible)
                    begin
                        rank_insert(0, req.user_index, req.post_count);
                        rank_insert(1, req.user_index, req.money);
                    end
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("response with no read request waiting: 0x%0h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("rank_user", 32'(want.rank_user), 32'(m_tdata[19:0]));
                    check_field("rank_value", want.rank_value, m_tdata[51:20]);
                    check_field("display_value", want.display_value, m_tdata[83:52]);
                    check_field("display_suffix", 32'(want.display_suffix),
                                32'(m_tdata[85:84]));
                    results_checked++;
                end
            end
        end
    end

    task automatic write_length(input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        lengths_used++;
    endtask

    task automatic queue_random(input int n);
        @(posedge clk);
        repeat (n)
            pending_reqs.push_back(random_request());
    endtask

    // drain everything, then let any offer still in the engine settle
    task automatic wait_idle();
        int w;
        w = 0;
        while ((pending_reqs.size() != 0 || s_tvalid || due_results.size() != 0)
               && w < 50000)
        begin
            @(posedge clk);
            w++;
        end
        if (due_results.size() != 0)
        begin
            $error("%0d expected responses never arrived", due_results.size());
            mismatches++;
            due_results.delete();
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // long receiver stall so the input queue backs up
    initial
    begin
        wait (results_checked >= 30);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (400) @(negedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #4000000;
        $error("run did not finish in time");
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0] lengths [8];
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        lengths = '{6'd0, 6'd1, 6'd32, 6'd63, 6'd4, 6'd17, 6'd2, 6'd30};
        lengths[6] = CFG_W'($urandom_range(2, 31));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty lists, extremes, scale thresholds, ties, ineligible
        pending_reqs.push_back(make_read(1'b0, 5'd0));
        pending_reqs.push_back(make_read(1'b1, 5'd31));
        pending_reqs.push_back(make_offer(20'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        pending_reqs.push_back(make_offer(20'd2, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        pending_reqs.push_back(make_offer(20'd3, 32'd500, 32'd500, 1'b0));
        pending_reqs.push_back(make_offer(20'd4, 32'd1000000000, 32'd1000000001, 1'b1));
        pending_reqs.push_back(make_offer(20'd5, 32'd1000000, 32'd1000001, 1'b1));
        pending_reqs.push_back(make_offer(20'd6, 32'd1000001, 32'd1000000, 1'b1));
        pending_reqs.push_back(make_offer(20'd7, 32'd1000000000, 32'd1000000, 1'b1));
        pending_reqs.push_back(make_offer(20'hF_FFFF, 32'd0, 32'd0, 1'b1));
        pending_reqs.push_back(make_offer(20'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        for (int r = 0; r < 6; r++)
        begin
            pending_reqs.push_back(make_read(1'b0, r[RANK_W-1:0]));
            pending_reqs.push_back(make_read(1'b1, r[RANK_W-1:0]));
        end
        pending_reqs.push_back(make_read(1'b0, 5'd29));
        pending_reqs.push_back(make_read(1'b1, 5'd30));
        queue_random(PHASE_ITEMS);
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_length(lengths[ph]);
            if (ph == 7)
                calm <= 1'b1;
            queue_random(PHASE_ITEMS);
            wait_idle();
        end

        $display("Covered %0d offer and %0d read requests across %0d list length settings.",
                 accepted_offers, accepted_reads, lengths_used);
        $display("%0d responses compared, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/core/dtk_pkg.sv
rtl/core/dtk_front.sv
rtl/core/dtk_list.sv
rtl/core/dtk_back.sv
rtl/core/dual_top_k_ranker_unit.sv
rtl/core/dtk_checker.sv
dv/dual_top_k_ranker_unit_tb.sv
